@@ rtl/xtt_pkg.sv @@
// ----------------------------------------------------------------------------
// xtt_pkg
// Types, character codes and byte classes shared by the XML tag tokenizer.
// ----------------------------------------------------------------------------
package xtt_pkg;

  typedef enum logic [4:0] {
    PH_TEXT, PH_LT, PH_BANG, PH_PCOMMENT, PH_PCDATA, PH_COMMENT, PH_PI,
    PH_CDATA, PH_EWS, PH_ENAME, PH_ETAIL, PH_SNAME, PH_BODY, PH_SLASH,
    PH_ANAME, PH_AEQ, PH_AWAIT, PH_AFIRST, PH_AVAL
  } phase_t;

  typedef enum logic [3:0] {
    TK_NONE, TK_TAG_NAME, TK_CLOSE_NAME, TK_ATTR_NAME, TK_ATTR_VALUE,
    TK_START_DONE, TK_EMPTY_DONE, TK_END_DONE, TK_VALUE_CLOSED
  } token_kind_t;

  typedef enum logic [1:0] {
    ST_RUN, ST_ERR_NOW, ST_END_OK, ST_END_ERR
  } status_t;

  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;

  // "!--" length, and the count of closing "--" or "]]" bytes before ">"
  localparam logic [2:0] COMMENT_OPEN_LEN = 3'd3;
  localparam logic [1:0] TERM_FULL        = 2'd2;

  function automatic logic is_ws(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
  endfunction

  function automatic logic is_nstart(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
           c == 8'h5F || c == 8'h3A;
  endfunction

  function automatic logic is_nchar(input logic [7:0] c);
    return is_nstart(c) || (c >= 8'h30 && c <= 8'h39) || c == CH_DASH ||
           c == 8'h2E;
  endfunction

  // "![CDATA[" by position
  function automatic logic [7:0] cdata_char(input logic [2:0] k);
    logic [7:0] r;
    unique case (k)
      3'd0: r = CH_BANG;
      3'd1: r = CH_LBRACK;
      3'd2: r = 8'h43;
      3'd3: r = 8'h44;
      3'd4: r = 8'h41;
      3'd5: r = 8'h54;
      3'd6: r = 8'h41;
      default: r = CH_LBRACK;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/xtt_in_if.sv @@
// ----------------------------------------------------------------------------
// xtt_in_if
// Input channel: one document byte per word.
// ----------------------------------------------------------------------------
interface xtt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       doc_last;

  modport source (output valid, in_byte, doc_last, input ready);
  modport sink   (input valid, in_byte, doc_last, output ready);
endinterface

@@ rtl/xtt_out_if.sv @@
// ----------------------------------------------------------------------------
// xtt_out_if
// Result channel: one token word per document byte.
// ----------------------------------------------------------------------------
interface xtt_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] token_kind;
  logic [7:0] out_byte;
  logic       token_first;
  logic [1:0] status;

  modport source (output valid, token_kind, out_byte, token_first, status,
                  input ready);
  modport sink   (input valid, token_kind, out_byte, token_first, status,
                  output ready);
endinterface

@@ rtl/xml_tag_tokenizer_unit.sv @@
// ----------------------------------------------------------------------------
// xml_tag_tokenizer_unit
// Streaming tokenizer for a subset of XML, one document byte per word.
// ----------------------------------------------------------------------------
// Takes one byte per clock unless dout stalls and returns one token word per
// byte, in the cycle after the byte is accepted. The parser state update is a
// single combinational step from the state registers and the incoming byte,
// so the sustained rate is one byte per cycle unless dout stalls. A single
// output register holds the result; din.ready is high whenever that register
// is empty or being read in the same cycle. After an error the block stays
// silent until the doc_last byte, which reports the final status and clears all state.
// ----------------------------------------------------------------------------
module xml_tag_tokenizer_unit import xtt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  xtt_in_if.sink    din,
  xtt_out_if.source dout
);

  phase_t      phase, phase_next;
  logic        quote_single, quote_single_next;
  logic [2:0]  prefix_count, prefix_count_next;
  logic [1:0]  terminator_count, terminator_count_next;
  logic        error_seen, error_seen_next;

  logic        out_valid;
  token_kind_t out_kind;
  logic [7:0]  out_byte;
  logic        out_first;
  status_t     out_status;

  token_kind_t kind;
  logic        first, err;
  status_t     st;
  phase_t      ph_eff;
  logic [7:0]  c;
  logic        accept;

  assign c         = din.in_byte;
  assign din.ready = !out_valid || dout.ready;
  assign accept    = din.valid && din.ready;

  always_comb begin
    ph_eff = phase;
    if (!is_nchar(c)) begin
      if (phase == PH_ENAME) ph_eff = PH_ETAIL;
      if (phase == PH_SNAME) ph_eff = PH_BODY;
      if (phase == PH_ANAME) ph_eff = PH_AEQ;
    end

    phase_next            = ph_eff;
    quote_single_next     = quote_single;
    prefix_count_next     = prefix_count;
    terminator_count_next = terminator_count;
    error_seen_next       = error_seen;
    kind  = TK_NONE;
    first = 1'b0;
    err   = 1'b0;

    if (!error_seen) begin
      unique case (ph_eff)
        PH_TEXT: if (c == CH_LT) phase_next = PH_LT;
        PH_LT: begin
          if (c == CH_BANG) phase_next = PH_BANG;
          else if (c == CH_QMARK) begin
            phase_next = PH_PI;
            terminator_count_next = '0;
          end else if (c == CH_SLASH) phase_next = PH_EWS;
          else if (is_nstart(c)) begin
            phase_next = PH_SNAME;
            kind = TK_TAG_NAME;
            first = 1'b1;
          end else err = 1'b1;
        end
        PH_BANG: begin
          if (c == CH_DASH) begin
            phase_next = PH_PCOMMENT;
            prefix_count_next = 3'd2;
          end else if (c == CH_LBRACK) begin
            phase_next = PH_PCDATA;
            prefix_count_next = 3'd2;
          end else err = 1'b1;
        end
        PH_PCOMMENT: begin
          if (prefix_count >= COMMENT_OPEN_LEN || c != CH_DASH) err = 1'b1;
          else if (prefix_count == COMMENT_OPEN_LEN - 3'd1) begin
            phase_next = PH_COMMENT;
            terminator_count_next = '0;
            prefix_count_next = '0;
          end else prefix_count_next = prefix_count + 3'd1;
        end
        PH_PCDATA: begin
          if (c != cdata_char(prefix_count)) err = 1'b1;
          else if (prefix_count == 3'd7) begin
            phase_next = PH_CDATA;
            terminator_count_next = '0;
            prefix_count_next = '0;
          end else prefix_count_next = prefix_count + 3'd1;
        end
        PH_COMMENT, PH_CDATA: begin
          if (c == ((ph_eff == PH_COMMENT) ? CH_DASH : CH_RBRACK)) begin
            if (terminator_count < TERM_FULL)
              terminator_count_next = terminator_count + 2'd1;
          end else if (c == CH_GT && terminator_count == TERM_FULL) begin
            phase_next = PH_TEXT;
            terminator_count_next = '0;
          end else terminator_count_next = '0;
        end
        PH_PI: begin
          if (c == CH_QMARK) terminator_count_next = 2'd1;
          else if (c == CH_GT && terminator_count == 2'd1) begin
            phase_next = PH_TEXT;
            terminator_count_next = '0;
          end else terminator_count_next = '0;
        end
        PH_EWS: begin
          if (!is_ws(c)) begin
            if (is_nstart(c)) begin
              phase_next = PH_ENAME;
              kind = TK_CLOSE_NAME;
              first = 1'b1;
            end else err = 1'b1;
          end
        end
        PH_ENAME: kind = TK_CLOSE_NAME;
        PH_ETAIL: begin
          if (!is_ws(c)) begin
            if (c == CH_GT) begin
              phase_next = PH_TEXT;
              kind = TK_END_DONE;
            end else err = 1'b1;
          end
        end
        PH_SNAME: kind = TK_TAG_NAME;
        PH_BODY: begin
          if (!is_ws(c)) begin
            if (c == CH_GT) begin
              phase_next = PH_TEXT;
              kind = TK_START_DONE;
            end else if (c == CH_SLASH) phase_next = PH_SLASH;
            else if (is_nstart(c)) begin
              phase_next = PH_ANAME;
              kind = TK_ATTR_NAME;
              first = 1'b1;
            end else err = 1'b1;
          end
        end
        PH_SLASH: begin
          if (c == CH_GT) begin
            phase_next = PH_TEXT;
            kind = TK_EMPTY_DONE;
          end else err = 1'b1;
        end
        PH_ANAME: kind = TK_ATTR_NAME;
        PH_AEQ: begin
          if (!is_ws(c)) begin
            if (c == CH_EQ) phase_next = PH_AWAIT;
            else err = 1'b1;
          end
        end
        PH_AWAIT: begin
          if (!is_ws(c)) begin
            if (c == CH_DQUOTE || c == CH_SQUOTE) begin
              quote_single_next = (c == CH_SQUOTE);
              phase_next = PH_AFIRST;
            end else err = 1'b1;
          end
        end
        PH_AFIRST, PH_AVAL: begin
          if (c == (quote_single ? CH_SQUOTE : CH_DQUOTE)) begin
            phase_next = PH_BODY;
            kind = TK_VALUE_CLOSED;
          end else begin
            kind = TK_ATTR_VALUE;
            first = (ph_eff == PH_AFIRST);
            phase_next = PH_AVAL;
          end
        end
        default: err = 1'b1;
      endcase
    end

    if (err) begin
      error_seen_next = 1'b1;
      kind = TK_NONE;
      first = 1'b0;
    end
    st = err ? ST_ERR_NOW : ST_RUN;

    if (din.doc_last) begin
      if (!error_seen_next && phase_next != PH_TEXT) error_seen_next = 1'b1;
      st = error_seen_next ? ST_END_ERR : ST_END_OK;
      phase_next            = PH_TEXT;
      quote_single_next     = 1'b0;
      prefix_count_next     = '0;
      terminator_count_next = '0;
      error_seen_next       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_TEXT;
      quote_single     <= 1'b0;
      prefix_count     <= '0;
      terminator_count <= '0;
      error_seen       <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (accept) begin
        phase            <= phase_next;
        quote_single     <= quote_single_next;
        prefix_count     <= prefix_count_next;
        terminator_count <= terminator_count_next;
        error_seen       <= error_seen_next;
        out_valid        <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_kind   <= kind;
      out_first  <= first;
      out_status <= st;
      out_byte   <= (kind == TK_TAG_NAME || kind == TK_CLOSE_NAME ||
                     kind == TK_ATTR_NAME || kind == TK_ATTR_VALUE) ? c : 8'h00;
    end
  end

  assign dout.valid       = out_valid;
  assign dout.token_kind  = out_kind;
  assign dout.out_byte    = out_byte;
  assign dout.token_first = out_first;
  assign dout.status      = out_status;

endmodule

@@ rtl/xtt_checker.sv @@
// ----------------------------------------------------------------------------
// xtt_checker
// Port-level checks for the XML tag tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module xtt_checker import xtt_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] token_kind,
  input logic [7:0] out_byte,
  input logic       token_first,
  input logic [1:0] status
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word present after reset");

  a_accept_gives_word: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted byte produced no result word");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(token_kind) &&
    $stable(out_byte) && $stable(token_first) && $stable(status))
    else $error("result word changed while stalled");

  a_first_on_byte_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_first |->
    (token_kind == TK_TAG_NAME || token_kind == TK_CLOSE_NAME ||
     token_kind == TK_ATTR_NAME || token_kind == TK_ATTR_VALUE))
    else $error("first flag on a kind without a byte");

  a_error_silent: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_ERR_NOW |->
    token_kind == TK_NONE && out_byte == 8'h00 && !token_first)
    else $error("token reported on an error byte");

endmodule

bind xml_tag_tokenizer_unit xtt_checker u_xtt_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (din.valid),
  .in_ready   (din.ready),
  .out_valid  (dout.valid),
  .out_ready  (dout.ready),
  .token_kind (dout.token_kind),
  .out_byte   (dout.out_byte),
  .token_first(dout.token_first),
  .status     (dout.status)
);

@@ tb/xtt_token_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtt_token_checker
// Watches both channels of the tokenizer, predicts the token word for every
// accepted byte and compares it with the word the block returns.
// ----------------------------------------------------------------------------
module xtt_token_checker import xtt_pkg::*; (
  input  logic clk,
  input  logic rst,
  xtt_in_if    din,
  xtt_out_if   dout,
  output int   errors,
  output int   pending
);

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] data;
    logic       first;
    logic [1:0] status;
  } token_word_t;

  localparam logic [23:0] COMMENT_OPEN = "!--";
  localparam logic [63:0] CDATA_OPEN   = "![CDATA[";

  phase_t      ph;
  logic        quote_sq;
  logic [2:0]  open_cnt;
  logic [1:0]  close_cnt;
  logic        doc_failed;
  token_word_t token_q[$];

  function automatic logic blank(input logic [7:0] c);
    return c inside {8'h20, 8'h09, 8'h0A, 8'h0D};
  endfunction

  function automatic logic name_head(input logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A], 8'h5F, 8'h3A};
  endfunction

  function automatic logic name_tail(input logic [7:0] c);
    return name_head(c) || (c inside {[8'h30:8'h39], 8'h2D, 8'h2E});
  endfunction

  task automatic clear_state();
    ph         = PH_TEXT;
    quote_sq   = 1'b0;
    open_cnt   = 3'd0;
    close_cnt  = 2'd0;
    doc_failed = 1'b0;
  endtask

  task automatic tokenize(input logic [7:0] c, input logic last);
    token_kind_t kind;
    status_t     st;
    logic        first, bad, redo, is_cd;
    logic [7:0]  lit, sym;
    int          k, plen;
    token_word_t w;
    kind  = TK_NONE;
    st    = ST_RUN;
    first = 1'b0;
    bad   = 1'b0;
    if (!doc_failed) begin
      redo = 1'b1;
      while (redo && !bad) begin
        redo = 1'b0;
        case (ph)
          PH_TEXT: if (c == CH_LT) ph = PH_LT;
          PH_LT: begin
            if (c == CH_BANG) ph = PH_BANG;
            else if (c == CH_QMARK) begin
              ph = PH_PI;
              close_cnt = 2'd0;
            end else if (c == CH_SLASH) ph = PH_EWS;
            else if (name_head(c)) begin
              ph = PH_SNAME;
              kind = TK_TAG_NAME;
              first = 1'b1;
            end else bad = 1'b1;
          end
          PH_BANG: begin
            if (c == CH_DASH) begin
              ph = PH_PCOMMENT;
              open_cnt = 3'd2;
            end else if (c == CH_LBRACK) begin
              ph = PH_PCDATA;
              open_cnt = 3'd2;
            end else bad = 1'b1;
          end
          PH_PCOMMENT, PH_PCDATA: begin
            k = int'(open_cnt);
            is_cd = (ph == PH_PCDATA);
            plen = is_cd ? 8 : 3;
            if (k >= plen) bad = 1'b1;
            else begin
              lit = is_cd ? CDATA_OPEN[63 - 8*k -: 8] : COMMENT_OPEN[23 - 8*k -: 8];
              if (c != lit) bad = 1'b1;
              else if (k + 1 == plen) begin
                ph = is_cd ? PH_CDATA : PH_COMMENT;
                close_cnt = 2'd0;
                open_cnt = 3'd0;
              end else open_cnt = open_cnt + 3'd1;
            end
          end
          PH_COMMENT, PH_CDATA: begin
            sym = (ph == PH_COMMENT) ? CH_DASH : CH_RBRACK;
            if (c == sym) begin
              if (close_cnt < 2'd2) close_cnt = close_cnt + 2'd1;
            end else if (c == CH_GT && close_cnt == 2'd2) begin
              ph = PH_TEXT;
              close_cnt = 2'd0;
            end else close_cnt = 2'd0;
          end
          PH_PI: begin
            if (c == CH_QMARK) close_cnt = 2'd1;
            else if (c == CH_GT && close_cnt == 2'd1) begin
              ph = PH_TEXT;
              close_cnt = 2'd0;
            end else close_cnt = 2'd0;
          end
          PH_EWS: begin
            if (!blank(c)) begin
              if (name_head(c)) begin
                ph = PH_ENAME;
                kind = TK_CLOSE_NAME;
                first = 1'b1;
              end else bad = 1'b1;
            end
          end
          PH_ENAME: begin
            if (name_tail(c)) kind = TK_CLOSE_NAME;
            else begin
              ph = PH_ETAIL;
              redo = 1'b1;
            end
          end
          PH_ETAIL: begin
            if (!blank(c)) begin
              if (c == CH_GT) begin
                ph = PH_TEXT;
                kind = TK_END_DONE;
              end else bad = 1'b1;
            end
          end
          PH_SNAME: begin
            if (name_tail(c)) kind = TK_TAG_NAME;
            else begin
              ph = PH_BODY;
              redo = 1'b1;
            end
          end
          PH_BODY: begin
            if (!blank(c)) begin
              if (c == CH_GT) begin
                ph = PH_TEXT;
                kind = TK_START_DONE;
              end else if (c == CH_SLASH) ph = PH_SLASH;
              else if (name_head(c)) begin
                ph = PH_ANAME;
                kind = TK_ATTR_NAME;
                first = 1'b1;
              end else bad = 1'b1;
            end
          end
          PH_SLASH: begin
            if (c == CH_GT) begin
              ph = PH_TEXT;
              kind = TK_EMPTY_DONE;
            end else bad = 1'b1;
          end
          PH_ANAME: begin
            if (name_tail(c)) kind = TK_ATTR_NAME;
            else begin
              ph = PH_AEQ;
              redo = 1'b1;
            end
          end
          PH_AEQ: begin
            if (!blank(c)) begin
              if (c == CH_EQ) ph = PH_AWAIT;
              else bad = 1'b1;
            end
          end
          PH_AWAIT: begin
            if (!blank(c)) begin
              if (c == CH_DQUOTE || c == CH_SQUOTE) begin
                quote_sq = (c == CH_SQUOTE);
                ph = PH_AFIRST;
              end else bad = 1'b1;
            end
          end
          PH_AFIRST, PH_AVAL: begin
            if (c == (quote_sq ? CH_SQUOTE : CH_DQUOTE)) begin
              ph = PH_BODY;
              kind = TK_VALUE_CLOSED;
            end else begin
              kind = TK_ATTR_VALUE;
              first = (ph == PH_AFIRST);
              ph = PH_AVAL;
            end
          end
          default: bad = 1'b1;
        endcase
      end
      if (bad) begin
        doc_failed = 1'b1;
        kind = TK_NONE;
        first = 1'b0;
        st = ST_ERR_NOW;
      end
    end
    if (last) begin
      if (ph != PH_TEXT) doc_failed = 1'b1;
      st = doc_failed ? ST_END_ERR : ST_END_OK;
    end
    w.kind   = kind;
    w.data   = (kind >= TK_TAG_NAME && kind <= TK_ATTR_VALUE) ? c : 8'h00;
    w.first  = first;
    w.status = st;
    token_q.insert(token_q.size(), w);
    if (last) clear_state();
  endtask

  always @(posedge clk) begin
    token_word_t got, want;
    if (rst) begin
      clear_state();
      token_q.delete();
      errors = 0;
    end else begin
      if (dout.valid === 1'b1 && dout.ready === 1'b1) begin
        got = {dout.token_kind, dout.out_byte, dout.token_first, dout.status};
        if (token_q.size() == 0) begin
          $display("%0t: unexpected word: kind %0d byte %h first %b status %0d",
                   $time, got.kind, got.data, got.first, got.status);
          errors++;
        end else begin
          want = token_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch: expected kind %0d byte %h first %b status %0d",
                     $time, want.kind, want.data, want.first, want.status);
            $display("%0t:           actual kind %0d byte %h first %b status %0d",
                     $time, got.kind, got.data, got.first, got.status);
            errors++;
          end
        end
      end
      if (din.valid === 1'b1 && din.ready === 1'b1) tokenize(din.in_byte, din.doc_last);
    end
    pending = token_q.size();
  end

endmodule

@@ tb/xml_tag_tokenizer_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_tag_tokenizer_unit_tb
// Feeds short XML documents, mostly well formed with random content and some
// corrupted, truncated or pure noise, byte by byte with random gaps on both
// channels; a checker predicts and compares every token word.
// ----------------------------------------------------------------------------
module xml_tag_tokenizer_unit_tb import xtt_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_BYTES = 750;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int          err_cnt;
  int          pend_cnt;
  int unsigned cycles = 0;
  int unsigned rx_hold = 0;
  int unsigned bytes_sent = 0;
  logic        tx_burst = 1'b0;
  logic [7:0]  doc[$];
  string       noise_set = "<>!?/=-[]'\" aZ:9";

  xtt_in_if  din ();
  xtt_out_if dout ();

  always #1 clk = ~clk;

  xml_tag_tokenizer_unit dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .dout (dout)
  );

  xtt_token_checker chk (
    .clk     (clk),
    .rst     (rst),
    .din     (din),
    .dout    (dout),
    .errors  (err_cnt),
    .pending (pend_cnt)
  );

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_byte(input logic [7:0] b);
    doc.insert(doc.size(), b);
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_from(input string set, input int unsigned max_n);
    repeat ($urandom_range(0, max_n)) add_byte(set[$urandom_range(0, set.len() - 1)]);
  endtask

  task automatic add_ws();
    add_from(" \t\n\r", 2);
  endtask

  task automatic add_name();
    string head, tail;
    head = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_:";
    tail = "0123456789-.AZaz_:";
    add_byte(head[$urandom_range(0, head.len() - 1)]);
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(0, 1)) add_byte(tail[$urandom_range(0, tail.len() - 1)]);
      else add_byte(head[$urandom_range(0, head.len() - 1)]);
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = tx_burst ? 0 : gap_len();
    if (gap != 0) begin
      din.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    din.valid    <= 1'b1;
    din.in_byte  <= b;
    din.doc_last <= last;
    @(posedge clk);
    while (din.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic send_doc();
    for (int i = 0; i < doc.size(); i++) push_byte(doc[i], i == doc.size() - 1);
    bytes_sent += doc.size();
  endtask

  task automatic drain();
    din.valid <= 1'b0;
    @(negedge clk);
    while (pend_cnt != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      dout.ready <= 1'b0;
      rx_hold    <= 0;
    end else if (rx_hold != 0) rx_hold <= rx_hold - 1;
    else if (dout.ready) begin
      dout.ready <= 1'b0;
      rx_hold    <= gap_len();
    end else begin
      dout.ready <= 1'b1;
      rx_hold    <= ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(0, 6);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[xml_tag_tokenizer_unit] ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned n, pick;
    logic [7:0]  q, v;
    din.valid    = 1'b0;
    din.in_byte  = 8'h00;
    din.doc_last = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed documents
    doc.delete(); add_str("<a b='x'c=\"\"/>"); send_doc();
    doc.delete(); add_str("</Z9 >"); send_doc();
    doc.delete(); add_str("<!x"); send_doc();
    doc.delete(); add_byte(8'hFF); add_byte(8'h00); send_doc();
    doc.delete(); add_str("<:"); send_doc();
    drain();

    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      doc.delete();
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 10)) begin
          v = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 1)) v = noise_set[$urandom_range(0, noise_set.len() - 1)];
          add_byte(v);
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(0, 5))
            0: repeat ($urandom_range(0, 3)) begin
              v = 8'($urandom_range(0, 255));
              if (v == CH_LT) v = 8'h20;
              add_byte(v);
            end
            1: begin
              add_byte(CH_LT);
              add_name();
              repeat ($urandom_range(0, 2)) begin
                add_ws();
                add_name();
                add_ws();
                add_byte(CH_EQ);
                add_ws();
                q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
                add_byte(q);
                repeat ($urandom_range(0, 3)) begin
                  v = 8'($urandom_range(0, 255));
                  if (v == q) v = v ^ 8'h01;
                  add_byte(v);
                end
                add_byte(q);
              end
              add_ws();
              if ($urandom_range(0, 1)) add_byte(CH_SLASH);
              add_byte(CH_GT);
            end
            2: begin
              add_byte(CH_LT);
              add_byte(CH_SLASH);
              add_ws();
              add_name();
              add_ws();
              add_byte(CH_GT);
            end
            3: begin
              add_str("<!--");
              add_from("->a ", 5);
              add_str("-->");
            end
            4: begin
              add_str("<?");
              add_from("?>x ", 5);
              add_str("?>");
            end
            default: begin
              add_str("<![CDATA[");
              add_from("]>x", 5);
              add_str("]]>");
            end
          endcase
        end
        if (doc.size() == 0) add_byte(8'h41);
        pick = $urandom_range(0, 9);
        if (pick == 0) doc[$urandom_range(0, doc.size() - 1)] = 8'($urandom_range(0, 255));
        else if (pick == 1 && doc.size() > 1) begin
          n = $urandom_range(1, doc.size() - 1);
          while (doc.size() > n) void'(doc.pop_back());
        end
      end
      tx_burst = ($urandom_range(0, 3) == 0);
      send_doc();
      if ($urandom_range(0, 24) == 0) drain();
    end

    drain();
    repeat (4) @(posedge clk);
    if (err_cnt == 0 && pend_cnt == 0) begin
      $display("[xml_tag_tokenizer_unit] OK");
    end else begin
      $display("[xml_tag_tokenizer_unit] ERROR");
    end
    $finish;
  end

endmodule
